// ----- rtl/rhh_pkg.sv -----
// Package for the bucketed hash table: constants, codes, controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rhh_pkg;
    localparam int HOME_SLOTS_DEF     = 4096;
    localparam int OVERFLOW_SLOTS_DEF = 64;
    localparam int BUCKET_WAYS        = 4;
    localparam int CFG_IDX_W          = 2;

    localparam logic [1:0] CFG_SIZE_LOG2   = 2'd0;
    localparam logic [1:0] CFG_MAX_SLOTS   = 2'd1;
    localparam logic [1:0] CFG_MAX_BUCKETS = 2'd2;
    localparam logic [1:0] CFG_FILL_PCT    = 2'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_REFUSED   = 3'd3;
    localparam logic [2:0] ST_PROBE_ERR = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_GROW, S_IRD, S_IWAIT, S_IEVAL,
        S_FRD, S_FWAIT, S_FEVAL, S_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic grow_calc;
        logic rd;
        logic ins_eval;
        logic find_eval;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic clear_done;
        logic grow;
        logic past_end;
        logic ins_done;
        logic find_done;
        logic is_find;
    } sts_t;
endpackage
`default_nettype wire

// ----- rtl/rhh_if.sv -----
// Valid/ready channel interfaces: item, result and config write.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rhh_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] hash_high;
    logic [63:0] hash_low;
    logic [63:0] value;
    modport source (output valid, cmd, hash_high, hash_low, value, input ready);
    modport sink (input valid, cmd, hash_high, hash_low, value, output ready);
endinterface

interface rhh_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] found_value;
    logic [12:0] entries_count;
    logic        grow_needed;
    modport source (output valid, status, found_value, entries_count, grow_needed,
                    input ready);
    modport sink (input valid, status, found_value, entries_count, grow_needed,
                  output ready);
endinterface

interface rhh_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [6:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/robin_hood_hash_table.sv -----
// Top level of the bucketed hash table: config registers, controller, datapath.
// Depends on rhh_pkg, rhh_if, rhh_ctrl, rhh_dp.
//  channel | dir | payload
//  in_ch   | in  | cmd, hash_high, hash_low, value
//  out_ch  | out | status, found_value, entries_count, grow_needed
//  cfg_ch  | in  | index, data
// After reset the store is swept clear, one bucket row per cycle.
// Insert: grow check, then a row read, wait and evaluate per probed slot;
// a refused insert ends at the grow check. Find: grow check, then a row read,
// wait and evaluate per bucket, up to the bucket bound.
// One item in flight; a stalled result holds the input off.
`timescale 1ns / 1ps
`default_nettype none
module robin_hood_hash_table
    import rhh_pkg::*;
#(
    parameter int HOME_SLOTS     = HOME_SLOTS_DEF,
    parameter int OVERFLOW_SLOTS = OVERFLOW_SLOTS_DEF
)(
    input wire logic clk,
    input wire logic rst_n,
    rhh_in_if.sink    in_ch,
    rhh_out_if.source out_ch,
    rhh_cfg_if.sink   cfg_ch
);
    logic [3:0] size_reg;
    logic [6:0] mslots_reg;
    logic [4:0] mbuck_reg;
    logic [6:0] pct_reg;
    ctl_t ctl;
    sts_t sts;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 4'd4;
            mslots_reg <= 7'd32;
            mbuck_reg <= 5'd8;
            pct_reg <= 7'd90;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_SIZE_LOG2:   size_reg <= cfg_ch.data[3:0];
                CFG_MAX_SLOTS:   mslots_reg <= cfg_ch.data;
                CFG_MAX_BUCKETS: mbuck_reg <= cfg_ch.data[4:0];
                CFG_FILL_PCT:    pct_reg <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    rhh_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .sts, .ctl
    );

    rhh_dp #(.HOME_SLOTS(HOME_SLOTS), .OVERFLOW_SLOTS(OVERFLOW_SLOTS)) u_dp (
        .clk, .rst_n, .ctl, .sts,
        .in_cmd(in_ch.cmd), .in_hh(in_ch.hash_high), .in_hl(in_ch.hash_low),
        .in_v(in_ch.value),
        .cfg_size_log2(size_reg), .cfg_max_slots(mslots_reg),
        .cfg_max_buckets(mbuck_reg), .cfg_fill_pct(pct_reg),
        .status(out_ch.status), .found_value(out_ch.found_value),
        .entries_count(out_ch.entries_count), .grow_needed(out_ch.grow_needed)
    );
endmodule
`default_nettype wire

// ----- rtl/rhh_ctrl.sv -----
// Controller FSM for the hash table: sequences clear, grow check, probes, result.
// Depends on rhh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rhh_ctrl
    import rhh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output ctl_t      ctl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_CLEAR;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_GROW;
            S_GROW:
            begin
                if (sts.is_find)      state_next = S_FRD;
                else if (sts.grow)    state_next = S_OUT;
                else                  state_next = S_IRD;
            end
            S_IRD:   state_next = sts.past_end ? S_OUT : S_IWAIT;
            S_IWAIT: state_next = S_IEVAL;
            S_IEVAL: state_next = sts.ins_done ? S_OUT : S_IRD;
            S_FRD:   state_next = sts.find_done ? S_OUT : S_FWAIT;
            S_FWAIT: state_next = S_FEVAL;
            S_FEVAL: state_next = sts.find_done ? S_OUT : S_FRD;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_CLEAR: ctl.clear_step = 1'b1;
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_GROW:  ctl.grow_calc = 1'b1;
            S_IRD:   ctl.rd = 1'b1;
            S_IEVAL: ctl.ins_eval = 1'b1;
            S_FRD:   ctl.rd = 1'b1;
            S_FEVAL: ctl.find_eval = 1'b1;
            S_OUT:
            begin
                out_valid = 1'b1;
                ctl.finish = out_ready;
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_ready) |=> state_reg == S_OUT)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("accept while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> state_reg == S_GROW)
        else $error("accepted item not started");
endmodule
`default_nettype wire

// ----- rtl/rhh_dp.sv -----
// Datapath: slot store memory, probe registers, bounds, fill counter and grow test.
// Depends on rhh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rhh_dp
    import rhh_pkg::*;
#(
    parameter int HOME_SLOTS     = HOME_SLOTS_DEF,
    parameter int OVERFLOW_SLOTS = OVERFLOW_SLOTS_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctl_t        ctl,
    output sts_t             sts,
    input  wire logic        in_cmd,
    input  wire logic [63:0] in_hh,
    input  wire logic [63:0] in_hl,
    input  wire logic [63:0] in_v,
    input  wire logic [3:0]  cfg_size_log2,
    input  wire logic [6:0]  cfg_max_slots,
    input  wire logic [4:0]  cfg_max_buckets,
    input  wire logic [6:0]  cfg_fill_pct,
    output logic [2:0]       status,
    output logic [63:0]      found_value,
    output logic [12:0]      entries_count,
    output logic             grow_needed
);
    localparam int DEPTH  = HOME_SLOTS + OVERFLOW_SLOTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW     = AW + 1;
    localparam int ROWS   = (DEPTH + BUCKET_WAYS - 1) / BUCKET_WAYS;
    localparam int RW     = $clog2(ROWS);
    localparam int HL2    = $clog2(HOME_SLOTS + 1) - 1;
    localparam int MAXL   = (HL2 < 12) ? HL2 : 12;
    localparam int CAPW   = SW;

    logic [191:0] rd_word [BUCKET_WAYS];
    logic [RW-1:0] clr_reg;

    logic         cmd_reg;
    logic [63:0]  hh_reg, hl_reg, v_reg;
    logic [SW-1:0] slot_reg;
    logic [2:0]   status_reg;
    logic [63:0]  fv_reg;
    logic [12:0]  used_reg;
    logic [6:0]   sbound_reg;
    logic [4:0]   bbound_reg;
    logic [4:0]   it_reg;
    logic         done_reg;

    logic [3:0] l_eff;
    logic [7:0] extra;
    logic [8:0] ov;
    logic [CAPW-1:0] cap;
    logic [19:0] used100;
    logic [CAPW+7:0] pcap;
    logic grow_now;

    logic [SW-3:0] rd_row;
    logic [191:0] cur;
    logic [63:0] ch, cl, cv;
    logic empty, swap, wr_en, ins_stop;
    logic [SW:0] nd, cd;
    logic [SW-1:0] chome, nhome;
    logic [SW:0] bd;
    logic [6:0] sb_new;
    logic [4:0] bb_new;
    logic [2:0] wh, wl;
    logic hit;

    // effective log2
    always_comb
    begin
        l_eff = cfg_size_log2;
        if (l_eff < 4'd2) l_eff = 4'd2;
        if (l_eff > 4'd12) l_eff = 4'd12;
        if (int'(l_eff) > MAXL) l_eff = 4'(MAXL);
    end

    function automatic logic [SW-1:0] home_f(input logic [63:0] h, input logic [3:0] l);
        logic [63:0] s;
        s = h >> (7'd64 - {3'd0, l});
        return s[SW-1:0];
    endfunction

    // capacity
    always_comb
    begin
        if ({1'b0, cfg_max_slots} > {1'b0, cfg_max_buckets, 2'b00})
            extra = {3'd0, cfg_max_slots[6:2]} - 8'd1;
        else
            extra = {3'd0, cfg_max_buckets} - 8'd1;
        if (extra[7]) extra = '0;
        ov = {extra[6:0], 2'b00};
        if (int'(ov) > OVERFLOW_SLOTS) ov = 9'(OVERFLOW_SLOTS);
        cap = (CAPW'(1) << l_eff) + CAPW'(ov);
    end

    // fill test: used*100 > pct*cap + (cap-1)  <=> floor(used*100/cap) > pct
    assign used100 = 20'(used_reg) * 20'd100;
    assign pcap = (CAPW+8)'(cfg_fill_pct) * (CAPW+8)'(cap) + (CAPW+8)'(cap) - (CAPW+8)'(1);
    assign grow_now = (sbound_reg > cfg_max_slots) || (bbound_reg > cfg_max_buckets)
                    || ((CAPW+21)'(used100) > (CAPW+21)'(pcap));

    // store banked by way: one row read per bank per cycle
    assign rd_row = slot_reg[SW-1:2];
    for (genvar w = 0; w < BUCKET_WAYS; w++)
    begin : g_bank
        logic [191:0] bank [ROWS];
        logic [191:0] row_reg;
        always_ff @(posedge clk)
        begin
            if (ctl.clear_step)
                bank[clr_reg] <= '0;
            else if (ctl.ins_eval && wr_en && slot_reg[1:0] == 2'(w))
                bank[slot_reg[RW+1:2]] <= {hh_reg, hl_reg, v_reg};
            if (rd_row < (SW-2)'(ROWS))
                row_reg <= bank[rd_row[RW-1:0]];
            else
                row_reg <= '0;
        end
        assign rd_word[w] = row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) clr_reg <= '0;
        else if (ctl.clear_step) clr_reg <= clr_reg + RW'(1);
    end
    assign sts.clear_done = (clr_reg == RW'(ROWS - 1));

    // insert evaluation on the probed slot
    assign cur = rd_word[slot_reg[1:0]];
    assign ch = cur[191:128];
    assign cl = cur[127:64];
    assign cv = cur[63:0];
    assign empty = (cur == '0);
    assign nhome = home_f(hh_reg, l_eff);
    assign chome = home_f(ch, l_eff);
    assign nd = {1'b0, slot_reg} - {1'b0, nhome};
    assign cd = {1'b0, slot_reg} - {1'b0, chome};
    assign swap = !empty && ($signed(nd) > $signed(cd));
    assign wr_en = empty || swap;
    assign ins_stop = empty || ($signed(cd) >= $signed({{(SW-6){1'b0}}, cfg_max_slots}));

    // distance note for placed entry
    always_comb
    begin
        sb_new = sbound_reg;
        bb_new = bbound_reg;
        bd = {3'b0, slot_reg[SW-1:2]} - {3'b0, nhome[SW-1:2]};
        if (bd[SW]) bd = -bd;
        if (nd[SW]) sb_new = 7'd127;
        else if (nd >= (SW+1)'(127)) sb_new = 7'd127;
        else if (nd[6:0] + 7'd1 > sbound_reg) sb_new = nd[6:0] + 7'd1;
        if (bd >= (SW+1)'(31)) bb_new = 5'd31;
        else if (bd[4:0] + 5'd1 > bbound_reg) bb_new = bd[4:0] + 5'd1;
    end

    // find match on bucket
    always_comb
    begin
        wh = 3'd4;
        wl = 3'd4;
        for (int w = BUCKET_WAYS - 1; w >= 0; w--)
        begin
            if (rd_word[w][191:128] == hh_reg) wh = 3'(w);
            if (rd_word[w][127:64] == hl_reg) wl = 3'(w);
        end
    end
    assign hit = (wh != 3'd4) && (wh == wl);

    assign sts.grow = grow_now;
    assign sts.is_find = cmd_reg;
    assign sts.past_end = (slot_reg >= SW'(DEPTH));
    assign sts.ins_done = ins_stop;
    assign sts.find_done = done_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_cmd;
            hh_reg <= in_hh;
            hl_reg <= in_hl;
            v_reg <= in_v;
            fv_reg <= '0;
            it_reg <= '0;
        end
        if (ctl.grow_calc)
        begin
            slot_reg <= cmd_reg ? {nhome[SW-1:2], 2'b00} : nhome;
            status_reg <= cmd_reg ? ST_NOT_FOUND : ST_REFUSED;
        end
        if (ctl.rd && !cmd_reg && sts.past_end)
            status_reg <= ST_PROBE_ERR;
        if (ctl.ins_eval)
        begin
            if (swap)
            begin
                hh_reg <= ch;
                hl_reg <= cl;
                v_reg <= cv;
            end
            if (empty) status_reg <= ST_INSERTED;
            else if (ins_stop) status_reg <= ST_PROBE_ERR;
            slot_reg <= slot_reg + SW'(1);
        end
        if (ctl.find_eval)
        begin
            if (hit)
            begin
                status_reg <= ST_FOUND;
                fv_reg <= rd_word[wl[1:0]][63:0];
            end
            it_reg <= it_reg + 5'd1;
            slot_reg <= slot_reg + SW'(BUCKET_WAYS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            sbound_reg <= '0;
            bbound_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (ctl.ins_eval && wr_en)
            begin
                sbound_reg <= sb_new;
                bbound_reg <= bb_new;
                if (empty && used_reg != 13'd8191) used_reg <= used_reg + 13'd1;
            end
            if (ctl.grow_calc)
                done_reg <= cmd_reg && (bbound_reg == 5'd0);
            if (ctl.find_eval)
                done_reg <= hit || (it_reg + 5'd1 >= bbound_reg);
        end
    end

    assign status = status_reg;
    assign found_value = fv_reg;
    assign entries_count = used_reg;
    assign grow_needed = grow_now;

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.ins_eval && empty && $past(used_reg) != 13'd8191 && used_reg != 13'd8191)
        |=> used_reg == $past(used_reg) + 13'd1)
        else $error("fill count not bumped on insert");
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(sbound_reg) <= sbound_reg || ctl.load)
        else $error("slot bound decreased");
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(bbound_reg) <= bbound_reg)
        else $error("bucket bound decreased");
endmodule
`default_nettype wire

// ----- test/robin_hood_hash_table_tb.sv -----
// Testbench for robin_hood_hash_table: random and directed insert/find beats,
// checked against a built-in table predictor. Depends on rhh_pkg, rhh_if and robin_hood_hash_table.
`timescale 1ns / 1ps
module robin_hood_hash_table_tb;
    import rhh_pkg::*;

    localparam int DEPTH = HOME_SLOTS_DEF + OVERFLOW_SLOTS_DEF;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] found_value;
        logic [12:0] entries_count;
        logic        grow_needed;
    } lookup_res_t;

    class table_scoreboard;
        logic [63:0] key_hi [DEPTH];
        logic [63:0] key_lo [DEPTH];
        logic [63:0] val_mem [DEPTH];
        int unsigned used, slot_bound, bucket_bound;
        logic [3:0] size_log2;
        logic [6:0] max_slots;
        logic [4:0] max_buckets;
        logic [6:0] fill_pct;
        lookup_res_t pending_q[$];

        function new();
            foreach (key_hi[i]) begin
                key_hi[i] = 0;
                key_lo[i] = 0;
                val_mem[i] = 0;
            end
            used = 0;
            slot_bound = 0;
            bucket_bound = 0;
            size_log2 = 4;
            max_slots = 32;
            max_buckets = 8;
            fill_pct = 90;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] data);
            case (idx)
                CFG_SIZE_LOG2:   size_log2 = data[3:0];
                CFG_MAX_SLOTS:   max_slots = data;
                CFG_MAX_BUCKETS: max_buckets = data[4:0];
                default:         fill_pct = data;
            endcase
        endfunction

        function int eff_log2();
            int l;
            l = size_log2;
            if (l < 2) l = 2;
            if (l > 12) l = 12;
            return l;
        endfunction

        function longint home(logic [63:0] hh);
            return longint'(hh >> (64 - eff_log2()));
        endfunction

        function bit grow_cond();
            longint extra, cap;
            if (max_slots > 4 * max_buckets) extra = longint'(max_slots / 4) - 1;
            else extra = longint'(max_buckets) - 1;
            if (extra < 0) extra = 0;
            extra = extra * BUCKET_WAYS;
            if (extra > OVERFLOW_SLOTS_DEF) extra = OVERFLOW_SLOTS_DEF;
            cap = (longint'(1) << eff_log2()) + extra;
            if (slot_bound > max_slots) return 1;
            if (bucket_bound > max_buckets) return 1;
            return (longint'(used) * 100) / cap > fill_pct;
        endfunction

        function void note_dist(logic [63:0] hh, longint slot);
            longint h, d, bd;
            h = home(hh);
            d = slot - h;
            bd = slot / BUCKET_WAYS - h / BUCKET_WAYS;
            if (d < 0) slot_bound = 127;
            else if (d + 1 > slot_bound) slot_bound = (d + 1 > 127) ? 127 : d + 1;
            if (bd < 0) bd = -bd;
            if (bd + 1 > bucket_bound) bucket_bound = (bd + 1 > 31) ? 31 : bd + 1;
        endfunction

        function logic [2:0] do_insert(logic [63:0] hh, logic [63:0] hl, logic [63:0] v);
            longint slot, nd, cd;
            logic [63:0] ch, cl, cv;
            if (grow_cond()) return ST_REFUSED;
            slot = home(hh);
            forever begin
                if (slot >= DEPTH) return ST_PROBE_ERR;
                nd = slot - home(hh);
                ch = key_hi[slot];
                cl = key_lo[slot];
                cv = val_mem[slot];
                if (ch == 0 && cl == 0 && cv == 0) begin
                    key_hi[slot] = hh;
                    key_lo[slot] = hl;
                    val_mem[slot] = v;
                    note_dist(hh, slot);
                    if (used < 8191) used++;
                    return ST_INSERTED;
                end
                cd = slot - home(ch);
                if (nd > cd) begin
                    key_hi[slot] = hh;
                    key_lo[slot] = hl;
                    val_mem[slot] = v;
                    note_dist(hh, slot);
                    hh = ch;
                    hl = cl;
                    v = cv;
                end
                if (cd >= longint'(max_slots)) return ST_PROBE_ERR;
                slot++;
            end
        endfunction

        function logic [63:0] rd_hi(longint s);
            return (s < 0 || s >= DEPTH) ? 64'd0 : key_hi[s];
        endfunction

        function logic [63:0] rd_lo(longint s);
            return (s < 0 || s >= DEPTH) ? 64'd0 : key_lo[s];
        endfunction

        function logic [2:0] do_find(logic [63:0] hh, logic [63:0] hl, output logic [63:0] v);
            longint base, b;
            int wh, wl;
            v = 0;
            base = (home(hh) / BUCKET_WAYS) * BUCKET_WAYS;
            for (int it = 0; it < bucket_bound; it++) begin
                b = base + it * BUCKET_WAYS;
                wh = -1;
                wl = -1;
                for (int w = 0; w < BUCKET_WAYS; w++)
                    if (wh < 0 && rd_hi(b + w) == hh) wh = w;
                if (wh < 0) continue;
                for (int w = 0; w < BUCKET_WAYS; w++)
                    if (wl < 0 && rd_lo(b + w) == hl) wl = w;
                if (wh == wl) begin
                    v = (b + wl < DEPTH) ? val_mem[b + wl] : 64'd0;
                    return ST_FOUND;
                end
            end
            return ST_NOT_FOUND;
        endfunction

        function void note_input(logic cmd, logic [63:0] hh, logic [63:0] hl, logic [63:0] v);
            lookup_res_t r;
            logic [63:0] fv;
            fv = 0;
            if (cmd == CMD_INSERT) r.status = do_insert(hh, hl, v);
            else r.status = do_find(hh, hl, fv);
            r.found_value = (r.status == ST_FOUND) ? fv : 64'd0;
            r.entries_count = used[12:0];
            r.grow_needed = grow_cond();
            pending_q.push_back(r);
        endfunction

        function string check_result(lookup_res_t got);
            lookup_res_t exp;
            if (pending_q.size() == 0) return "result beat with nothing expected";
            exp = pending_q.pop_front();
            if (got.status !== exp.status)
                return $sformatf("status %0d, expected %0d", got.status, exp.status);
            if (got.found_value !== exp.found_value)
                return $sformatf("found_value %h, expected %h", got.found_value,
                                 exp.found_value);
            if (got.entries_count !== exp.entries_count)
                return $sformatf("entries_count %0d, expected %0d", got.entries_count,
                                 exp.entries_count);
            if (got.grow_needed !== exp.grow_needed)
                return $sformatf("grow_needed %0b, expected %0b", got.grow_needed,
                                 exp.grow_needed);
            return "";
        endfunction
    endclass

    logic clk;
    logic rst_n;
    rhh_in_if  in_ch();
    rhh_out_if out_ch();
    rhh_cfg_if cfg_ch();

    robin_hood_hash_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    table_scoreboard sb;
    int errors;
    bit quiet;
    bit hold_req;
    logic [191:0] known_keys[$];

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10ms;
        $display("robin_hood_hash_table: mismatch");
        $finish;
    end

    task automatic report(string msg);
        errors++;
        $display("ERROR %0t: %s", $realtime, msg);
    endtask

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    // result sink with random stalls and one long hold-off
    initial begin
        lookup_res_t got;
        string msg;
        int gap;
        out_ch.ready = 0;
        wait (rst_n);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 0;
                repeat (300) @(posedge clk);
                hold_req = 0;
            end
            gap = draw_gap();
            if (gap > 0) begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            got.status = out_ch.status;
            got.found_value = out_ch.found_value;
            got.entries_count = out_ch.entries_count;
            got.grow_needed = out_ch.grow_needed;
            msg = sb.check_result(got);
            if (msg != "") report(msg);
        end
    end

    task automatic send(logic cmd, logic [63:0] hh, logic [63:0] hl, logic [63:0] v);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.cmd <= cmd;
        in_ch.hash_high <= hh;
        in_ch.hash_low <= hl;
        in_ch.value <= v;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(cmd, hh, hl, v);
        if (cmd == CMD_INSERT) begin
            known_keys.push_back({hh, hl, v});
            if (known_keys.size() > 200) void'(known_keys.pop_front());
        end
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] data);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 0;
        sb.set_reg(idx, data);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // crowd keys onto few home slots so probes and swaps happen
    function automatic logic [63:0] rand_high();
        logic [63:0] h;
        h = rand64();
        if ($urandom_range(0, 9) < 7) h[63:52] = $urandom_range(0, 40);
        return h;
    endfunction

    task automatic random_item();
        logic [191:0] k;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50 || known_keys.size() == 0) begin
            send(CMD_INSERT, rand_high(), rand64(), rand64());
        end else if (pick < 90) begin
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            send(CMD_FIND, k[191:128], k[127:64], rand64());
        end else begin
            send(CMD_FIND, rand_high(), rand64(), rand64());
        end
    endtask

    initial begin
        logic [6:0] cfg_set [7][4] = '{
            '{4, 32, 8, 90}, '{2, 1, 1, 100}, '{15, 127, 31, 127}, '{0, 0, 0, 1},
            '{12, 64, 16, 100}, '{6, 20, 3, 50}, '{9, 5, 1, 100}
        };
        sb = new();
        errors = 0;
        quiet = 0;
        hold_req = 0;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.cmd = CMD_INSERT;
        in_ch.hash_high = 0;
        in_ch.hash_low = 0;
        in_ch.value = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = CFG_SIZE_LOG2;
        cfg_ch.data = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) drain();
            write_reg(CFG_SIZE_LOG2, cfg_set[ph][0]);
            write_reg(CFG_MAX_SLOTS, cfg_set[ph][1]);
            write_reg(CFG_MAX_BUCKETS, cfg_set[ph][2]);
            write_reg(CFG_FILL_PCT, cfg_set[ph][3]);
            quiet = (ph == 2 || ph == 5);
            if (ph == 0) begin
                send(CMD_FIND, 64'd5, 64'd6, 64'd0);
                send(CMD_INSERT, 64'd0, 64'd0, 64'd0);
                send(CMD_FIND, 64'd0, 64'd0, 64'd0);
                send(CMD_INSERT, '1, '1, '1);
                send(CMD_FIND, '1, '1, 64'd0);
                send(CMD_INSERT, 64'h0123_4567_89ab_cdef, 64'd1, 64'h55);
                send(CMD_INSERT, 64'h0123_4567_89ab_cdef, 64'd2, 64'hAA);
                send(CMD_INSERT, 64'h0123_4567_89ab_cdef, 64'd1, 64'h77);
                send(CMD_FIND, 64'h0123_4567_89ab_cdef, 64'd2, '1);
                send(CMD_FIND, 64'h0123_4567_89ab_cdef, 64'd1, 64'd0);
                send(CMD_FIND, 64'h0123_4567_89ab_cdef, 64'd3, 64'd0);
                send(CMD_INSERT, 64'h0, '1, 64'd0);
                send(CMD_FIND, 64'h0, '1, 64'd0);
                send(CMD_INSERT, 64'h8000_0000_0000_0000, 64'd0, 64'd0);
                for (int i = 0; i < 6; i++)
                    send(CMD_INSERT, 64'h0800_0000_0000_0000 + i, i, i + 1);
                send(CMD_FIND, 64'h0800_0000_0000_0003, 64'd3, 64'd0);
            end
            for (int i = 0; i < 70; i++) begin
                if (ph == 1 && i == 20) hold_req = 1;
                if (ph == 4 && i == 35) drain();
                random_item();
            end
        end

        drain();
        if (errors == 0)
            $display("robin_hood_hash_table: match");
        else
            $display("robin_hood_hash_table: mismatch");
        $finish;
    end
endmodule
